// ===== hdl/bsg_pkg.sv =====
// bsg_pkg: shared constants, codes and types of the step generator
`default_nettype none
package bsg_pkg;

	localparam int POS_BITS_DEF   = 24;
	localparam int DELAY_BITS_DEF = 16;
	localparam int CFG_IDX_BITS   = 1;

	localparam int START_DELAY_RST  = 1000;
	localparam int CRUISE_DELAY_RST = 100;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_STEP   = 2'd1;
	localparam logic [1:0] FUNC_SETPOS = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_START_DELAY  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CRUISE_DELAY = 1'b1;

	typedef struct packed {
		logic load;
		logic advance;
		logic setpos;
	} axis_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/bsg_ifs.sv =====
// bsg_ifs: command, result and register write channel interfaces
`default_nettype none
interface bsg_cmd_if #(
	parameter int POS_BITS = bsg_pkg::POS_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic signed [POS_BITS-1:0] target_x;
	logic signed [POS_BITS-1:0] target_y;

	modport source (output valid, func, target_x, target_y, input ready);
	modport sink   (input valid, func, target_x, target_y, output ready);
endinterface

interface bsg_res_if #(
	parameter int DELAY_BITS = bsg_pkg::DELAY_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  step_x;
	logic                  step_y;
	logic                  dir_x;
	logic                  dir_y;
	logic [DELAY_BITS-1:0] delay_us;
	logic                  done_res;

	modport source (output valid, step_x, step_y, dir_x, dir_y, delay_us, done_res,
		input ready);
	modport sink   (input valid, step_x, step_y, dir_x, dir_y, delay_us, done_res,
		output ready);
endinterface

interface bsg_cfg_if #(
	parameter int DELAY_BITS = bsg_pkg::DELAY_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [bsg_pkg::CFG_IDX_BITS-1:0]  index;
	logic [DELAY_BITS-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bresenham_step_generator_ramp.sv =====
// bresenham_step_generator_ramp: two-axis step generator with trapezoid ramp
//
// channel  dir  beat                                   accepted when
// cmd      in   func, target_x, target_y               cmd.valid && cmd.ready
// res      out  step_x/y, dir_x/y, delay_us, done_res  res.valid && res.ready
// cfg      in   index, data                            cfg.valid && cfg.ready
//
// one command beat per clock while the result is not stalled; its result goes through
// the input register, then the result register; the state updates as it enters the latter
// reset clears position, move state and result valid, registers to their defaults
// a stalled result holds the input stage; cmd.ready falls only when both are full
// cfg.ready is always high
`default_nettype none
module bresenham_step_generator_ramp #(
	parameter int POS_BITS   = bsg_pkg::POS_BITS_DEF,
	parameter int DELAY_BITS = bsg_pkg::DELAY_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	bsg_cmd_if.sink     cmd,
	bsg_res_if.source   res,
	bsg_cfg_if.sink     cfg
);

	localparam int W = (POS_BITS > DELAY_BITS) ? POS_BITS : DELAY_BITS;

	// registers
	logic [DELAY_BITS-1:0] start_delay_q;
	logic [DELAY_BITS-1:0] cruise_delay_q;

	// input stage
	logic                valid_s1;
	logic [1:0]          func_s1;
	logic [POS_BITS-1:0] tx_s1;
	logic [POS_BITS-1:0] ty_s1;

	// move state
	logic [POS_BITS-1:0]   major_q;
	logic [POS_BITS-1:0]   step_index_q;
	logic [POS_BITS-1:0]   ramp_q;
	logic [POS_BITS-1:0]   decel_q;
	logic [DELAY_BITS-1:0] cur_delay_q;

	// result register
	logic                  out_valid_q;
	logic                  step_x_q;
	logic                  step_y_q;
	logic                  dir_x_q;
	logic                  dir_y_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic                  done_q;

	logic                  adv_s1;
	logic                  fire;
	logic                  active;
	bsg_pkg::axis_ctrl_t   ctrl;
	logic [POS_BITS-1:0]   dx;
	logic [POS_BITS-1:0]   dy;
	logic                  dir_x;
	logic                  dir_y;
	logic                  pulse_x;
	logic                  pulse_y;
	logic [POS_BITS-1:0]   major_nxt;
	logic [POS_BITS-1:0]   half_nxt;
	logic [DELAY_BITS-1:0] ramp_diff;
	logic [POS_BITS-1:0]   ramp_nxt;
	logic [POS_BITS-1:0]   step_index_inc;
	logic [DELAY_BITS-1:0] delay_dec;
	logic [DELAY_BITS-1:0] delay_nxt;
	logic                  done_nxt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q  <= DELAY_BITS'(bsg_pkg::START_DELAY_RST);
			cruise_delay_q <= DELAY_BITS'(bsg_pkg::CRUISE_DELAY_RST);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bsg_pkg::REG_START_DELAY:  start_delay_q  <= cfg.data;
				bsg_pkg::REG_CRUISE_DELAY: cruise_delay_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1    = !out_valid_q || res.ready;
	assign fire      = valid_s1 && adv_s1;
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			func_s1 <= cmd.func;
			tx_s1   <= cmd.target_x;
			ty_s1   <= cmd.target_y;
		end
	end

	assign active       = step_index_q < major_q;
	assign ctrl.load    = fire && (func_s1 == bsg_pkg::FUNC_LOAD);
	assign ctrl.advance = fire && (func_s1 == bsg_pkg::FUNC_STEP) && active;
	assign ctrl.setpos  = fire && (func_s1 == bsg_pkg::FUNC_SETPOS);

	bsg_axis #(.POS_BITS(POS_BITS)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.target (tx_s1),
		.major  (major_q),
		.delta  (dx),
		.dir    (dir_x),
		.pulse  (pulse_x)
	);

	bsg_axis #(.POS_BITS(POS_BITS)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.target (ty_s1),
		.major  (major_q),
		.delta  (dy),
		.dir    (dir_y),
		.pulse  (pulse_y)
	);

	// move planning on load
	assign major_nxt = (dx > dy) ? dx : dy;
	assign half_nxt  = major_nxt >> 1;
	assign ramp_diff = (start_delay_q > cruise_delay_q) ?
		(start_delay_q - cruise_delay_q) : '0;
	assign ramp_nxt  = (W'(ramp_diff) > W'(half_nxt)) ? half_nxt : POS_BITS'(ramp_diff);

	// ramp up, then ramp down, both saturating
	assign step_index_inc = step_index_q + 1'b1;
	assign delay_dec = ((step_index_q < ramp_q) && (cur_delay_q != '0)) ?
		(cur_delay_q - 1'b1) : cur_delay_q;
	assign delay_nxt = ((step_index_q >= decel_q) && (delay_dec != '1)) ?
		(delay_dec + 1'b1) : delay_dec;

	always_comb begin
		if (ctrl.load) begin
			done_nxt = (major_nxt == '0);
		end else if (ctrl.advance) begin
			done_nxt = (step_index_inc >= major_q);
		end else begin
			done_nxt = !active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q      <= '0;
			step_index_q <= '0;
			ramp_q       <= '0;
			decel_q      <= '0;
			cur_delay_q  <= '0;
		end else if (ctrl.load) begin
			major_q      <= major_nxt;
			step_index_q <= '0;
			ramp_q       <= ramp_nxt;
			decel_q      <= major_nxt - ramp_nxt;
			cur_delay_q  <= start_delay_q;
		end else if (ctrl.advance) begin
			step_index_q <= step_index_inc;
			cur_delay_q  <= delay_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_x_q <= pulse_x;
			step_y_q <= pulse_y;
			dir_x_q  <= dir_x;
			dir_y_q  <= dir_y;
			delay_q  <= ctrl.advance ? delay_nxt : '0;
			done_q   <= done_nxt;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.step_x   = step_x_q;
	assign res.step_y   = step_y_q;
	assign res.dir_x    = dir_x_q;
	assign res.dir_y    = dir_y_q;
	assign res.delay_us = delay_q;
	assign res.done_res = done_q;

`ifndef ASSERT_OFF
	a_index_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		step_index_q <= major_q)
		else $error("step index beyond major step count");
	a_ramp_before_decel: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= decel_q)
		else $error("ramp end lies after decel start");
	a_decel_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		decel_q <= major_q)
		else $error("decel start beyond major step count");
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed beat gave no result");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && out_valid_q))
		else $error("command stalled with a free stage");
`endif

endmodule
`default_nettype wire

// ===== hdl/bsg_axis.sv =====
// bsg_axis: one axis: position, delta, direction and bresenham accumulator
`default_nettype none
module bsg_axis #(
	parameter int POS_BITS = bsg_pkg::POS_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  bsg_pkg::axis_ctrl_t      ctrl,
	input  wire [POS_BITS-1:0]       target,
	input  wire [POS_BITS-1:0]       major,
	output logic [POS_BITS-1:0]      delta,
	output logic                     dir,
	output logic                     pulse
);

	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] dist_q;
	logic [POS_BITS:0]   acc_q;
	logic                dir_q;

	logic [POS_BITS:0]   diff;
	logic [POS_BITS:0]   diff_abs;
	logic                positive;
	logic [POS_BITS:0]   acc_sum;

	// signed difference, one bit wider so it cannot overflow
	assign diff     = {target[POS_BITS-1], target} - {pos_q[POS_BITS-1], pos_q};
	assign diff_abs = diff[POS_BITS] ? (~diff + 1'b1) : diff;
	assign positive = !diff[POS_BITS] && (diff != '0);
	assign delta    = diff_abs[POS_BITS-1:0];

	assign acc_sum = acc_q + {1'b0, dist_q};
	assign pulse   = ctrl.advance && (acc_sum >= {1'b0, major});
	assign dir     = ctrl.load ? positive : dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dist_q <= '0;
			acc_q  <= '0;
			dir_q  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				dist_q <= delta;
				acc_q  <= '0;
				dir_q  <= positive;
			end else if (ctrl.advance) begin
				acc_q <= pulse ? (acc_sum - {1'b0, major}) : acc_sum;
			end
			if (ctrl.setpos) begin
				pos_q <= target;
			end else if (pulse) begin
				pos_q <= dir_q ? (pos_q + 1'b1) : (pos_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== bench/step_check_pkg.sv =====
// step_check_pkg: step generator predictor and store of expected result beats
`timescale 1ns / 100ps
package step_check_pkg;
	import bsg_pkg::*;

	localparam int PW = POS_BITS_DEF;
	localparam int DW = DELAY_BITS_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic          step_x;
		logic          step_y;
		logic          dir_x;
		logic          dir_y;
		logic [DW-1:0] delay_us;
		logic          done_res;
	} step_result_t;

	class step_scoreboard;
		logic [PW-1:0] pos_x, pos_y;
		logic [PW-1:0] dist_x, dist_y;
		logic [PW:0]   acc_x, acc_y;
		logic [PW-1:0] major, step_no, ramp_len, decel_at;
		logic [DW-1:0] delay_now;
		logic [DW-1:0] start_dly, cruise_dly;
		logic [1:0]    dirs;
		step_result_t  expected_q[$];
		int mismatches, checked;
		int loads, advances, pos_sets, pulses;

		function new();
			start_dly  = DW'(START_DELAY_RST);
			cruise_dly = DW'(CRUISE_DELAY_RST);
			pos_x = '0;
			pos_y = '0;
			dist_x = '0;
			dist_y = '0;
			acc_x = '0;
			acc_y = '0;
			major = '0;
			step_no = '0;
			ramp_len = '0;
			decel_at = '0;
			delay_now = '0;
			dirs = '0;
			mismatches = 0;
			checked = 0;
			loads = 0;
			advances = 0;
			pos_sets = 0;
			pulses = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DW-1:0] val);
			if (idx == REG_START_DELAY)
				start_dly = val;
			else if (idx == REG_CRUISE_DELAY)
				cruise_dly = val;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function logic [PW-1:0] span(logic [PW-1:0] goal, logic [PW-1:0] from,
			output logic fwd);
			longint d;
			d = longint'($signed(goal)) - longint'($signed(from));
			fwd = d > 0;
			if (d < 0)
				d = -d;
			return PW'(d);
		endfunction

		function void note_command(logic [1:0] func, logic [PW-1:0] tx, logic [PW-1:0] ty);
			step_result_t r;
			logic fx, fy;
			r = '0;
			case (func)
				FUNC_LOAD: begin
					loads++;
					dist_x = span(tx, pos_x, fx);
					dist_y = span(ty, pos_y, fy);
					dirs = {fy, fx};
					major = (dist_x > dist_y) ? dist_x : dist_y;
					acc_x = '0;
					acc_y = '0;
					step_no = '0;
					ramp_len = (start_dly > cruise_dly) ? PW'(start_dly - cruise_dly) : '0;
					if (ramp_len > (major >> 1))
						ramp_len = major >> 1;
					decel_at = major - ramp_len;
					delay_now = start_dly;
				end
				FUNC_STEP: begin
					advances++;
					if (step_no < major) begin
						acc_x = acc_x + dist_x;
						if (acc_x >= major) begin
							acc_x = acc_x - major;
							r.step_x = 1'b1;
							pos_x = dirs[0] ? pos_x + 1'b1 : pos_x - 1'b1;
						end
						acc_y = acc_y + dist_y;
						if (acc_y >= major) begin
							acc_y = acc_y - major;
							r.step_y = 1'b1;
							pos_y = dirs[1] ? pos_y + 1'b1 : pos_y - 1'b1;
						end
						if (step_no < ramp_len && delay_now != '0)
							delay_now = delay_now - 1'b1;
						if (step_no >= decel_at && delay_now != '1)
							delay_now = delay_now + 1'b1;
						step_no = step_no + 1'b1;
						r.delay_us = delay_now;
						pulses += int'(r.step_x) + int'(r.step_y);
					end
				end
				FUNC_SETPOS: begin
					pos_sets++;
					pos_x = tx;
					pos_y = ty;
				end
				default: ;
			endcase
			r.dir_x = dirs[0];
			r.dir_y = dirs[1];
			r.done_res = step_no >= major;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_field(string name, logic [DW-1:0] got, logic [DW-1:0] want);
			if (got !== want)
				report($sformatf("result %0d %s is %0h, expected %0h", checked, name, got, want));
		endtask

		task check_result(step_result_t got);
			step_result_t want;
			if (expected_q.size() == 0) begin
				report("result beat with no command outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			check_field("step_x", DW'(got.step_x), DW'(want.step_x));
			check_field("step_y", DW'(got.step_y), DW'(want.step_y));
			check_field("dir_x", DW'(got.dir_x), DW'(want.dir_x));
			check_field("dir_y", DW'(got.dir_y), DW'(want.dir_y));
			check_field("delay_us", got.delay_us, want.delay_us);
			check_field("done_res", DW'(got.done_res), DW'(want.done_res));
		endtask
	endclass

endpackage

// ===== bench/bresenham_step_generator_ramp_tb.sv =====
// bresenham_step_generator_ramp_tb: randomised and directed check of the step generator
`timescale 1ns / 100ps
module bresenham_step_generator_ramp_tb;
	import bsg_pkg::*;
	import step_check_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 240;
	localparam int POS_HI      = (1 << (PW - 1)) - 1;
	localparam int POS_LO      = -(1 << (PW - 1));

	logic clk;
	logic arst_n;

	bsg_cmd_if cmd_bus ();
	bsg_res_if res_bus ();
	bsg_cfg_if cfg_bus ();

	bresenham_step_generator_ramp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	step_scoreboard sb;
	step_result_t   seen;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_req;
	int sent;
	int nom_x, nom_y;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			seen = '{step_x: res_bus.step_x, step_y: res_bus.step_y, dir_x: res_bus.dir_x,
				dir_y: res_bus.dir_y, delay_us: res_bus.delay_us, done_res: res_bus.done_res};
			sb.check_result(seen);
		end
		if (arst_n && cmd_bus.valid && cmd_bus.ready)
			sb.note_command(cmd_bus.func, cmd_bus.target_x, cmd_bus.target_y);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic int clamp(int v);
		return (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
	endfunction

	function automatic int pick_pos();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 2 * POS_HI + 1)) + POS_LO;
			1: return $urandom_range(0, 1) ? POS_HI - int'($urandom_range(0, 3))
				: POS_LO + int'($urandom_range(0, 3));
			default: return int'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic send_cmd(logic [1:0] func, int tx, int ty);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid    <= 1'b1;
		cmd_bus.func     <= func;
		cmd_bus.target_x <= PW'(tx);
		cmd_bus.target_y <= PW'(ty);
		do @(posedge clk); while (!cmd_bus.ready);
		sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= DW'(val);
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_reg(idx, DW'(val));
	endtask

	task automatic drain();
		@(negedge clk) cmd_bus.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_move(int reach);
		int tx, ty, steps;
		tx = clamp(nom_x + int'($urandom_range(0, 2 * reach)) - reach);
		ty = clamp(nom_y + int'($urandom_range(0, 2 * reach)) - reach);
		steps = (tx > nom_x) ? tx - nom_x : nom_x - tx;
		if (((ty > nom_y) ? ty - nom_y : nom_y - ty) > steps)
			steps = (ty > nom_y) ? ty - nom_y : nom_y - ty;
		send_cmd(FUNC_LOAD, tx, ty);
		repeat (steps + int'($urandom_range(0, 2))) send_cmd(FUNC_STEP, $urandom, $urandom);
		nom_x = tx;
		nom_y = ty;
	endtask

	task automatic run_broken();
		case ($urandom_range(0, 2))
			0: begin
				send_cmd(FUNC_LOAD, clamp(nom_x + int'($urandom_range(0, 40)) - 20),
					clamp(nom_y + int'($urandom_range(0, 40)) - 20));
				repeat ($urandom_range(0, 4)) send_cmd(FUNC_STEP, $urandom, $urandom);
				send_cmd(FUNC_SETPOS, pick_pos(), pick_pos());
				repeat ($urandom_range(1, 6)) send_cmd(FUNC_STEP, $urandom, $urandom);
			end
			1: begin
				repeat (2) begin
					send_cmd(FUNC_LOAD, clamp(nom_x + int'($urandom_range(0, 40)) - 20),
						clamp(nom_y + int'($urandom_range(0, 40)) - 20));
					repeat ($urandom_range(0, 5)) send_cmd(FUNC_STEP, $urandom, $urandom);
				end
			end
			default: begin
				repeat ($urandom_range(2, 8))
					send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom);
			end
		endcase
		nom_x = pick_pos();
		nom_y = pick_pos();
		send_cmd(FUNC_SETPOS, nom_x, nom_y);
	endtask

	initial begin : main
		int s_dly, c_dly, stop_at, pick;
		sb = new();
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.func = FUNC_STEP;
		cmd_bus.target_x = '0;
		cmd_bus.target_y = '0;
		res_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_START_DELAY;
		cfg_bus.data = '0;
		hold_left = 0;
		hold_req = 1'b0;
		sent = 0;
		nom_x = 0;
		nom_y = 0;
		send_idle_pct = 38;
		recv_idle_pct = 50;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed part at reset register values
		send_cmd(FUNC_STEP, '0, '0);
		send_cmd(FUNC_UNUSED, '1, '1);
		send_cmd(FUNC_LOAD, '0, '0);
		send_cmd(FUNC_STEP, '0, '0);
		send_cmd(FUNC_LOAD, 5, -2);
		repeat (6) send_cmd(FUNC_STEP, '0, '0);
		send_cmd(FUNC_SETPOS, POS_HI, POS_LO);
		send_cmd(FUNC_LOAD, POS_LO, POS_HI);
		repeat (2) send_cmd(FUNC_STEP, '1, '1);
		// reload while moving
		send_cmd(FUNC_LOAD, POS_HI, POS_LO);
		send_cmd(FUNC_STEP, '0, '0);
		// position set mid-move, x wraps
		send_cmd(FUNC_SETPOS, POS_HI, POS_HI);
		repeat (2) send_cmd(FUNC_STEP, '0, '0);
		send_cmd(FUNC_SETPOS, '0, '0);
		send_cmd(FUNC_LOAD, -3, 7);
		repeat (3) send_cmd(FUNC_STEP, '0, '0);
		send_cmd(FUNC_SETPOS, '0, '0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin s_dly = 20;    c_dly = 5;     end
				1: begin s_dly = 1;     c_dly = 65535; end
				2: begin s_dly = 65535; c_dly = 1;     end
				3: begin s_dly = 12;    c_dly = 11;    end
				4: begin s_dly = 65535; c_dly = 65535; end
				default: begin s_dly = 9; c_dly = 1; end
			endcase
			if (p == 2) begin
				send_idle_pct = 50;
				recv_idle_pct = 38;
			end
			if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(REG_START_DELAY, s_dly);
			write_reg(REG_CRUISE_DELAY, c_dly);
			@(negedge clk) cfg_bus.valid <= 1'b0;
			if (p == 4)
				hold_req = 1'b1;
			stop_at = sent + PHASE_ITEMS;
			while (sent < stop_at) begin
				pick = $urandom_range(0, 99);
				if (pick < 62) begin
					run_move((pick < 57) ? 30 : 300);
				end else if (pick < 72) begin
					nom_x = pick_pos();
					nom_y = pick_pos();
					send_cmd(FUNC_SETPOS, nom_x, nom_y);
				end else begin
					run_broken();
				end
			end
			drain();
		end

		$display("%0d commands: %0d loads, %0d advances with %0d axis pulses, %0d position sets",
			sent, sb.loads, sb.advances, sb.pulses, sb.pos_sets);
		$display("%0d result beats checked across %0d delay settings, %0d mismatches",
			sb.checked, PHASES + 1, sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bsg_pkg.sv
hdl/bsg_ifs.sv
hdl/bsg_axis.sv
hdl/bresenham_step_generator_ramp.sv
bench/step_check_pkg.sv
bench/bresenham_step_generator_ramp_tb.sv
